FILE: src/tsb_pkg.sv
// shared definitions for the text screen buffer: command codes, character
// constants, controller/datapath interface structs and the bar cell function
// no dependencies
package tsb_pkg;

  // default geometry
  localparam int DEF_COLUMNS = 16;
  localparam int DEF_LINES   = 6;

  // command codes
  localparam logic [2:0] OP_WRITE        = 3'd0;
  localparam logic [2:0] OP_CLEAR_SCREEN = 3'd1;
  localparam logic [2:0] OP_CLEAR_LINE   = 3'd2;
  localparam logic [2:0] OP_GOTO         = 3'd3;
  localparam logic [2:0] OP_BAR          = 3'd4;
  localparam logic [2:0] OP_READ         = 3'd5;
  localparam logic [2:0] OP_ACK          = 3'd6;

  // character codes
  localparam logic [7:0] CODE_SPACE      = 8'h20;
  localparam logic [7:0] CODE_PRINT_LAST = 8'h89;
  localparam logic [7:0] CODE_BAR_FULL   = 8'h89;
  localparam logic [7:0] CODE_BAR_BASE   = 8'h81;
  localparam logic [7:0] CODE_LF         = 8'h0A;
  localparam logic [7:0] CODE_CR         = 8'h0D;
  localparam logic [7:0] CODE_BS         = 8'h08;
  localparam logic [7:0] CODE_RESET      = 8'h41;

  // bar height limit in pixels, pixels per character row
  localparam logic [7:0] BAR_MAX_HEIGHT = 8'd40;
  localparam logic [5:0] BAR_ROW_PIXELS = 6'd8;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic fill_load;
    logic fill_write;
    logic bar_load;
    logic bar_write;
    logic set_dirty;
    logic read_take;
    logic result;
  } tsb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       fill_last;
    logic       bar_last;
    logic       bar_skip;
    logic       bar_empty;
  } tsb_stat_t;

  // character for one bar row given the pixels still to draw
  function automatic logic [7:0] bar_cell(input logic [5:0] hgt);
    logic [7:0] code;
    if (hgt >= BAR_ROW_PIXELS) begin
      code = CODE_BAR_FULL;
    end else if (hgt != 6'd0) begin
      code = CODE_BAR_BASE + {2'b00, hgt};
    end else begin
      code = CODE_SPACE;
    end
    return code;
  endfunction

endpackage

FILE: src/tsb_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tsb_ctrl.sv
// command sequencer for the text screen buffer
// depends on tsb_pkg
module tsb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tsb_pkg::tsb_stat_t stat,
  output logic              busy,
  output tsb_pkg::tsb_cmd_t  cmd
);

  import tsb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_BAR  = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op) inside
          OP_CLEAR_SCREEN, OP_CLEAR_LINE: begin
            cmd.fill_load = 1'b1;
            state_next    = S_FILL;
          end
          OP_BAR: begin
            if (stat.bar_skip) begin
              cmd.result = 1'b1;
              state_next = S_IDLE;
            end else if (stat.bar_empty) begin
              cmd.set_dirty = 1'b1;
              cmd.result    = 1'b1;
              state_next    = S_IDLE;
            end else begin
              cmd.bar_load = 1'b1;
              state_next   = S_BAR;
            end
          end
          OP_READ: begin
            state_next = S_READ;
          end
          default: begin
            cmd.exec   = 1'b1;
            cmd.result = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        if (stat.fill_last) begin
          cmd.set_dirty = 1'b1;
          cmd.result    = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_BAR: begin
        cmd.bar_write = 1'b1;
        if (stat.bar_last) begin
          cmd.set_dirty = 1'b1;
          cmd.result    = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_READ: begin
        cmd.read_take = 1'b1;
        cmd.result    = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/tsb_datapath.sv
// datapath of the text screen buffer: command registers, cursor, sweep
// counters, screen ram with per-cell valid bits and result registers
// depends on tsb_pkg and tsb_ram
module tsb_datapath #(
  parameter int COLUMNS = tsb_pkg::DEF_COLUMNS,
  parameter int LINES   = tsb_pkg::DEF_LINES
) (
  input  logic               clk,
  input  logic               rst,
  input  tsb_pkg::tsb_cmd_t  cmd,
  output tsb_pkg::tsb_stat_t stat,
  input  logic [2:0]         op,
  input  logic [7:0]         code_in,
  input  logic [3:0]         col_in,
  input  logic [2:0]         row_in,
  input  logic [7:0]         bar_height,
  input  logic [3:0]         bar_rows,
  output logic               done,
  output logic [7:0]         read_code,
  output logic [3:0]         cursor_col,
  output logic [2:0]         cursor_row,
  output logic               update_pending
);

  import tsb_pkg::*;

  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] COL_LAST  = 4'(COLUMNS - 1);
  localparam logic [2:0] ROW_LAST  = 3'(LINES - 1);
  localparam logic [4:0] COL_LIMIT = 5'(COLUMNS);
  localparam logic [3:0] ROW_LIMIT = 4'(LINES);

  // captured command
  logic [2:0] cmd_op;
  logic [7:0] cmd_code;
  logic [3:0] cmd_col;
  logic [2:0] cmd_row;
  logic [7:0] cmd_height;
  logic [3:0] cmd_rows;

  // cursor and flag
  logic [3:0] cur_col;
  logic [2:0] cur_row;
  logic       dirty;

  // sweep counters
  logic [2:0] row_cnt;
  logic [3:0] col_cnt;
  logic [2:0] row_stop;
  logic [3:0] bar_left;
  logic [5:0] bar_hgt;

  // storage
  logic [DEPTH-1:0] valid;
  logic             valid_rd;
  logic [7:0]       rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [AW-1:0]    raddr;

  // decoded
  logic       printable;
  logic       col_ok;
  logic       row_ok;
  logic [2:0] row_inc;
  logic [3:0] put_col;
  logic [2:0] put_row;

  assign cursor_col     = cur_col;
  assign cursor_row     = cur_row;
  assign update_pending = dirty;

  assign col_ok = ({1'b0, cmd_col} < COL_LIMIT);
  assign row_ok = ({1'b0, cmd_row} < ROW_LIMIT);
  assign raddr  = {cmd_row[RW-1:0], cmd_col[CW-1:0]};

  assign stat.op        = cmd_op;
  assign stat.fill_last = (col_cnt == COL_LAST) && (row_cnt == row_stop);
  assign stat.bar_last  = (bar_left == 4'd1);
  assign stat.bar_skip  = !col_ok;
  assign stat.bar_empty = (cmd_rows == 4'd0);

  // cursor movement for a character write
  always_comb begin
    printable = (cmd_code >= CODE_SPACE) && (cmd_code <= CODE_PRINT_LAST);
    row_inc   = (cur_row == ROW_LAST) ? 3'd0 : cur_row + 3'd1;
    put_col   = cur_col;
    put_row   = cur_row;
    if (printable) begin
      if (cur_col == COL_LAST) begin
        put_col = 4'd0;
        put_row = row_inc;
      end else begin
        put_col = cur_col + 4'd1;
      end
    end else if (cmd_code == CODE_LF) begin
      put_row = row_inc;
    end else if (cmd_code == CODE_CR) begin
      put_col = 4'd0;
    end else if (cmd_code == CODE_BS) begin
      if (cur_col != 4'd0) begin
        put_col = cur_col - 4'd1;
      end
    end
  end

  // ram write port select
  always_comb begin
    we    = 1'b0;
    waddr = {cur_row[RW-1:0], cur_col[CW-1:0]};
    wdata = cmd_code;
    if (cmd.fill_write) begin
      we    = 1'b1;
      waddr = {row_cnt[RW-1:0], col_cnt[CW-1:0]};
      wdata = CODE_SPACE;
    end else if (cmd.bar_write) begin
      we    = 1'b1;
      waddr = {row_cnt[RW-1:0], cmd_col[CW-1:0]};
      wdata = bar_cell(bar_hgt);
    end else if (cmd.exec && (cmd_op == OP_WRITE) && printable) begin
      we = 1'b1;
    end
  end

  tsb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 4'd0;
      cur_row <= 3'd0;
      dirty   <= 1'b0;
      done    <= 1'b0;
      valid   <= '0;
    end else begin
      done <= cmd.result;
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (cmd.exec) begin
        case (cmd_op)
          OP_WRITE: begin
            cur_col <= put_col;
            cur_row <= put_row;
            if (printable) begin
              dirty <= 1'b1;
            end
          end
          OP_GOTO: begin
            if (col_ok) begin
              cur_col <= cmd_col;
            end
            if (row_ok) begin
              cur_row <= cmd_row;
            end
          end
          OP_ACK: begin
            dirty <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.set_dirty) begin
        dirty <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_op     <= op;
      cmd_code   <= code_in;
      cmd_col    <= col_in;
      cmd_row    <= row_in;
      cmd_height <= bar_height;
      cmd_rows   <= bar_rows;
    end
    if (cmd.fill_load) begin
      row_cnt  <= (cmd_op == OP_CLEAR_SCREEN) ? 3'd0 : cur_row;
      row_stop <= (cmd_op == OP_CLEAR_SCREEN) ? ROW_LAST : cur_row;
      col_cnt  <= 4'd0;
    end
    if (cmd.fill_write) begin
      if (col_cnt == COL_LAST) begin
        col_cnt <= 4'd0;
        row_cnt <= row_cnt + 3'd1;
      end else begin
        col_cnt <= col_cnt + 4'd1;
      end
    end
    if (cmd.bar_load) begin
      row_cnt  <= ROW_LAST;
      bar_left <= (cmd_rows > ROW_LIMIT) ? ROW_LIMIT : cmd_rows;
      bar_hgt  <= (cmd_height > BAR_MAX_HEIGHT) ? BAR_MAX_HEIGHT[5:0] : cmd_height[5:0];
    end
    if (cmd.bar_write) begin
      row_cnt  <= row_cnt - 3'd1;
      bar_left <= bar_left - 4'd1;
      bar_hgt  <= (bar_hgt >= BAR_ROW_PIXELS) ? bar_hgt - BAR_ROW_PIXELS : 6'd0;
    end
    valid_rd <= valid[raddr];
    if (cmd.result) begin
      if (cmd.read_take && col_ok && row_ok) begin
        read_code <= valid_rd ? rdata : CODE_RESET;
      end else begin
        read_code <= 8'd0;
      end
    end
  end

endmodule

FILE: src/text_screen_buffer_with_cursor.sv
// top level of the text screen buffer with cursor
// depends on tsb_pkg, tsb_ctrl, tsb_datapath (and through it tsb_ram)
//
// A command is taken at a rising edge where start is high and busy is low.
// Its one result (read_code, cursor_col, cursor_row, update_pending) is shown
// for exactly one cycle with done high; the receiver cannot hold it off, so
// it must take the transfer in that cycle. Cursor and flag ports also follow
// the live state between results. busy rises the cycle after start is taken
// and falls as done rises, so a new command may be started while done is
// still high. Commands pass through these sequencer states:
//   write code, goto, acknowledge, unused code: execute only
//   read cell: execute, then read (registered ram read)
//   clear line: execute, then one fill step per column
//   clear screen: execute, then one fill step per cell
//   bar: execute, then one bar step per clamped row (none if column off screen)
// The screen ram has a single write port, so clears and bars write one cell
// per cycle. After reset every cell reads as 'A' through per-cell valid bits,
// so no clearing pass is needed and a command can be started at once.
module text_screen_buffer_with_cursor #(
  parameter int COLUMNS = tsb_pkg::DEF_COLUMNS,
  parameter int LINES   = tsb_pkg::DEF_LINES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] code_in,
  input  logic [3:0] col_in,
  input  logic [2:0] row_in,
  input  logic [7:0] bar_height,
  input  logic [3:0] bar_rows,
  output logic       done,
  output logic [7:0] read_code,
  output logic [3:0] cursor_col,
  output logic [2:0] cursor_row,
  output logic       update_pending
);

  import tsb_pkg::*;

  // command and status between sequencer and datapath
  tsb_cmd_t  cmd;
  tsb_stat_t stat;

  // sequencer: idle, execute, fill sweep, bar sweep, read
  tsb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  // datapath: cursor, flag, sweep counters, screen ram, result registers
  tsb_datapath #(
    .COLUMNS(COLUMNS),
    .LINES  (LINES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .code_in       (code_in),
    .col_in        (col_in),
    .row_in        (row_in),
    .bar_height    (bar_height),
    .bar_rows      (bar_rows),
    .done          (done),
    .read_code     (read_code),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .update_pending(update_pending)
  );

endmodule

FILE: tb/tb_text_screen_buffer_with_cursor.sv
`timescale 1ns / 100ps
// self-checking testbench for text_screen_buffer_with_cursor: directed and random commands,
// every result checked against a shadow screen kept in a small scoreboard class
// depends on tsb_pkg and the text_screen_buffer_with_cursor rtl
module tb_text_screen_buffer_with_cursor;
  import tsb_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int LINES   = DEF_LINES;

  // op code with no command behind it, should leave all state alone
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_COMMANDS = 725;
  // longest quiet stretch is a full clear plus a gap
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [2:0] op;
    logic [7:0] code;
    logic [3:0] col;
    logic [2:0] row;
    logic [7:0] height;
    logic [3:0] rows;
  } screen_cmd_t;

  typedef struct {
    logic [7:0] read_code;
    logic [3:0] cursor_col;
    logic [2:0] cursor_row;
    logic       update_pending;
  } screen_status_t;

  // shadow copy of the screen, cursor and update flag; one expected status per command
  class screen_shadow;
    logic [7:0]     cells [COLUMNS*LINES];
    int             col_pos;
    int             row_pos;
    bit             dirty;
    screen_status_t pending_status [$];
    int             mismatches;
    int             checked;
    int             op_seen [8];

    function new();
      foreach (cells[i]) cells[i] = CODE_RESET;
      col_pos    = 0;
      row_pos    = 0;
      dirty      = 0;
      mismatches = 0;
      checked    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void blank_row(int r);
      for (int c = 0; c < COLUMNS; c++) cells[r*COLUMNS + c] = CODE_SPACE;
      dirty = 1;
    endfunction

    // apply one accepted command and queue the status it must produce
    function void note_command(screen_cmd_t c);
      screen_status_t s;
      int             h;
      int             n;
      s.read_code = '0;
      op_seen[c.op]++;
      case (c.op)
        OP_WRITE: begin
          if (c.code >= CODE_SPACE && c.code <= CODE_PRINT_LAST) begin
            cells[row_pos*COLUMNS + col_pos] = c.code;
            dirty = 1;
            col_pos++;
            if (col_pos >= COLUMNS) begin
              col_pos = 0;
              row_pos++;
            end
          end else if (c.code == CODE_LF) begin
            row_pos++;
          end else if (c.code == CODE_CR) begin
            col_pos = 0;
          end else if (c.code == CODE_BS) begin
            if (col_pos != 0) col_pos--;
          end
          if (row_pos >= LINES) row_pos = 0;
        end
        OP_CLEAR_SCREEN: begin
          for (int r = 0; r < LINES; r++) blank_row(r);
        end
        OP_CLEAR_LINE: begin
          blank_row(row_pos);
        end
        OP_GOTO: begin
          // each coordinate only taken when it is on screen
          if (c.col < COLUMNS) col_pos = c.col;
          if (c.row < LINES) row_pos = c.row;
        end
        OP_BAR: begin
          if (c.col < COLUMNS) begin
            h = (c.height > BAR_MAX_HEIGHT) ? BAR_MAX_HEIGHT : c.height;
            n = (c.rows > LINES) ? LINES : c.rows;
            // fill upward from the bottom row
            for (int i = 0; i < n; i++) begin
              if (h >= BAR_ROW_PIXELS) begin
                cells[(LINES-1-i)*COLUMNS + c.col] = CODE_BAR_FULL;
                h -= BAR_ROW_PIXELS;
              end else if (h > 0) begin
                cells[(LINES-1-i)*COLUMNS + c.col] = 8'(CODE_BAR_BASE + h);
                h = 0;
              end else begin
                cells[(LINES-1-i)*COLUMNS + c.col] = CODE_SPACE;
              end
            end
            dirty = 1;
          end
        end
        OP_READ: begin
          if (c.col < COLUMNS && c.row < LINES) s.read_code = cells[c.row*COLUMNS + c.col];
        end
        OP_ACK: begin
          dirty = 0;
        end
        default: begin
        end
      endcase
      s.cursor_col     = col_pos[3:0];
      s.cursor_row     = row_pos[2:0];
      s.update_pending = dirty;
      pending_status.push_back(s);
    endfunction

    function void check_result(screen_status_t got);
      screen_status_t want;
      if (pending_status.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      checked++;
      if (got.read_code !== want.read_code) begin
        $error("read_code: expected %0h, actual %0h", want.read_code, got.read_code);
        mismatches++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, actual %0d", want.cursor_col, got.cursor_col);
        mismatches++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, actual %0d", want.cursor_row, got.cursor_row);
        mismatches++;
      end
      if (got.update_pending !== want.update_pending) begin
        $error("update_pending: expected %0b, actual %0b", want.update_pending,
               got.update_pending);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] op = OP_WRITE;
  logic [7:0] code_in = '0;
  logic [3:0] col_in = '0;
  logic [2:0] row_in = '0;
  logic [7:0] bar_height = '0;
  logic [3:0] bar_rows = '0;
  logic       done;
  logic [7:0] read_code;
  logic [3:0] cursor_col;
  logic [2:0] cursor_row;
  logic       update_pending;

  int idle_cycles = 0;

  screen_shadow shadow = new();

  always #6 clk = ~clk;

  text_screen_buffer_with_cursor u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .code_in        (code_in),
    .col_in         (col_in),
    .row_in         (row_in),
    .bar_height     (bar_height),
    .bar_rows       (bar_rows),
    .done           (done),
    .read_code      (read_code),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .update_pending (update_pending)
  );

  // present one command, hold it until the transfer, then note it in the shadow.
  // start is left high after the transfer so a back-to-back command never
  // lowers and raises it in the same step
  task automatic send_command(screen_cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= c.op;
    code_in    <= c.code;
    col_in     <= c.col;
    row_in     <= c.row;
    bar_height <= c.height;
    bar_rows   <= c.rows;
    // transfer happens at the first edge with busy low
    do @(posedge clk); while (busy !== 1'b0);
    shadow.note_command(c);
  endtask

  function automatic screen_cmd_t make_command(logic [2:0] o, logic [7:0] code, logic [3:0] col,
                                               logic [2:0] row, logic [7:0] height,
                                               logic [3:0] rows);
    screen_cmd_t c;
    c.op     = o;
    c.code   = code;
    c.col    = col;
    c.row    = row;
    c.height = height;
    c.rows   = rows;
    return c;
  endfunction

  // weighted command mix; fields the op ignores still get random values
  function automatic screen_cmd_t random_command();
    screen_cmd_t c;
    int          pick;
    c.op     = OP_WRITE;
    c.code   = 8'($urandom_range(0, 255));
    c.col    = 4'($urandom_range(0, 15));
    c.row    = 3'($urandom_range(0, 7));
    c.height = 8'($urandom_range(0, 255));
    c.rows   = 4'($urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      // mostly printable text, some control codes, the rest anything
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        c.code = 8'($urandom_range(CODE_SPACE, CODE_PRINT_LAST));
      end else if (pick < 8) begin
        case ($urandom_range(0, 2))
          0: c.code = CODE_LF;
          1: c.code = CODE_CR;
          default: c.code = CODE_BS;
        endcase
      end
    end else if (pick < 57) begin
      c.op = OP_GOTO;
    end else if (pick < 77) begin
      c.op = OP_READ;
      if ($urandom_range(0, 3) != 0) c.row = 3'($urandom_range(0, LINES - 1));
    end else if (pick < 86) begin
      c.op = OP_BAR;
      if ($urandom_range(0, 3) != 0) c.height = 8'($urandom_range(0, 48));
    end else if (pick < 91) begin
      c.op = OP_ACK;
    end else if (pick < 95) begin
      c.op = OP_CLEAR_LINE;
    end else if (pick < 97) begin
      c.op = OP_CLEAR_SCREEN;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // result side: done marks a one-cycle transfer that must be taken now
  always @(posedge clk) begin : result_monitor
    screen_status_t seen;
    if (!rst) begin
      if (done === 1'b1) begin
        seen.read_code      = read_code;
        seen.cursor_col     = cursor_col;
        seen.cursor_row     = cursor_row;
        seen.update_pending = update_pending;
        shadow.check_result(seen);
      end
      if ((start && busy === 1'b0) || done === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    screen_cmd_t directed [$];
    directed.push_back(make_command(OP_READ, 8'h00, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, CODE_SPACE, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, CODE_PRINT_LAST, 4'd0, 3'd0, 8'd0, 4'd0));
    // codes outside the printable window are ignored
    directed.push_back(make_command(OP_WRITE, 8'h1F, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, 8'h8A, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, 8'hFF, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, 8'h00, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, CODE_BS, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, CODE_CR, 4'd0, 3'd0, 8'd0, 4'd0));
    // backspace at column zero stays put
    directed.push_back(make_command(OP_WRITE, CODE_BS, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, CODE_LF, 4'd0, 3'd0, 8'd0, 4'd0));
    // write in the last cell wraps column and row back to zero
    directed.push_back(make_command(OP_GOTO, 8'h00, 4'd15, 3'd5, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, 8'h5A, 4'd0, 3'd0, 8'd0, 4'd0));
    // goto with row off screen only moves the column
    directed.push_back(make_command(OP_GOTO, 8'h00, 4'd4, 3'd7, 8'd0, 4'd0));
    directed.push_back(make_command(OP_GOTO, 8'h00, 4'd9, 3'd5, 8'd0, 4'd0));
    directed.push_back(make_command(OP_WRITE, CODE_LF, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_ACK, 8'h00, 4'd0, 3'd0, 8'd0, 4'd0));
    // bars: height above the limit with rows above LINES, partial cell, empty bar
    directed.push_back(make_command(OP_BAR, 8'h00, 4'd3, 3'd0, 8'd255, 4'd8));
    directed.push_back(make_command(OP_BAR, 8'h00, 4'd4, 3'd0, 8'd13, 4'd3));
    directed.push_back(make_command(OP_BAR, 8'h00, 4'd5, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_READ, 8'h00, 4'd3, 3'd0, 8'd0, 4'd0));
    // read with row off screen returns zero
    directed.push_back(make_command(OP_READ, 8'h00, 4'd2, 3'd6, 8'd0, 4'd0));
    directed.push_back(make_command(OP_CLEAR_LINE, 8'h00, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_CLEAR_SCREEN, 8'h00, 4'd0, 3'd0, 8'd0, 4'd0));
    directed.push_back(make_command(OP_UNUSED, 8'h00, 4'd0, 3'd0, 8'd0, 4'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_command(directed[i], $urandom_range(0, 5));

    // every third block of 60 commands runs with no gaps at all
    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      send_command(random_command(), ((i / 60) % 3 == 1) ? 0 : $urandom_range(0, 5));
    end
    start <= 1'b0;

    while (shadow.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d writes, %0d screen clears, %0d line clears, %0d gotos, %0d bars,",
             shadow.op_seen[OP_WRITE], shadow.op_seen[OP_CLEAR_SCREEN],
             shadow.op_seen[OP_CLEAR_LINE], shadow.op_seen[OP_GOTO], shadow.op_seen[OP_BAR]);
    $display("%0d reads, %0d acks, %0d unused ops; %0d results checked, %0d mismatches",
             shadow.op_seen[OP_READ], shadow.op_seen[OP_ACK], shadow.op_seen[OP_UNUSED],
             shadow.checked, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
src/tsb_pkg.sv
src/tsb_ram.sv
src/tsb_ctrl.sv
src/tsb_datapath.sv
src/text_screen_buffer_with_cursor.sv
tb/tb_text_screen_buffer_with_cursor.sv
